@@ hdl/sphere_to_shape_distance_macros.svh @@
// Assertion macros used by the checker file of the distance block.
`ifndef SPHERE_TO_SHAPE_DISTANCE_MACROS_SVH
`define SPHERE_TO_SHAPE_DISTANCE_MACROS_SVH

// Checked while out of reset.
`define STSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define STSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/stsd_pkg.sv @@
// Shared constants and types of the sphere-to-shape distance block.
package stsd_pkg;

  // Packed vector component width; axes carry COMPONENT_BITS-2 fraction bits.
  localparam int COMPONENT_BITS = 21;
  localparam int AXF = COMPONENT_BITS - 2;
  localparam int SZW = 24;
  localparam int QW = 64;
  localparam int RW = QW / 2;

  localparam logic [SZW-1:0] DIST_MAX = '1;

  typedef enum logic [2:0] {
    KIND_SPHERE     = 3'd0,
    KIND_TRIANGLE   = 3'd1,
    KIND_PLATE      = 3'd2,
    KIND_PLATE_HOLE = 3'd3,
    KIND_CYLINDER   = 3'd4
  } kind_t;

  // Side data that rides along the square-root pipeline.
  typedef struct packed {
    logic [2:0]     kind;
    logic           dzero;
    logic [SZW-1:0] sz1;
  } sq_tag_t;

endpackage

@@ hdl/stsd_isqrt.sv @@
// Pipelined integer square root, four result bits per stage.
module stsd_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [stsd_pkg::QW-1:0]     in_q,
  input  stsd_pkg::sq_tag_t           in_tag,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stsd_pkg::RW-1:0]     out_root,
  output stsd_pkg::sq_tag_t           out_tag
);

  localparam int BPS = 4;                       // root bits per stage
  localparam int NS = stsd_pkg::RW / BPS;
  localparam int RMW = stsd_pkg::RW + 4;        // remainder width

  logic [NS-1:0]             vld_r;
  logic [NS:0]               adv;
  logic [RMW-1:0]            rem_r  [NS];
  logic [RMW-1:0]            rem_nxt [NS];
  logic [stsd_pkg::RW-1:0]   root_r [NS];
  logic [stsd_pkg::RW-1:0]   root_nxt [NS];
  logic [stsd_pkg::QW-1:0]   qs_r   [NS];
  logic [stsd_pkg::QW-1:0]   qs_nxt [NS];
  stsd_pkg::sq_tag_t         tag_r  [NS];

  // A stage moves when it is empty or the next one moves.
  always_comb begin
    adv[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  // Digit-by-digit restoring root, BPS steps per stage.
  always_comb begin
    logic [RMW-1:0]          rem;
    logic [RMW-1:0]          trial;
    logic [stsd_pkg::RW-1:0] root;
    logic [stsd_pkg::QW-1:0] qs;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rem  = '0;
        root = '0;
        qs   = in_q;
      end else begin
        rem  = rem_r[k-1];
        root = root_r[k-1];
        qs   = qs_r[k-1];
      end
      for (int j = 0; j < BPS; j++) begin
        rem   = {rem[RMW-3:0], qs[stsd_pkg::QW-1 -: 2]};
        qs    = {qs[stsd_pkg::QW-3:0], 2'b00};
        trial = {{(RMW-stsd_pkg::RW-2){1'b0}}, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[stsd_pkg::RW-2:0], 1'b1};
        end else begin
          root = {root[stsd_pkg::RW-2:0], 1'b0};
        end
      end
      rem_nxt[k]  = rem;
      root_nxt[k] = root;
      qs_nxt[k]   = qs;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[k-1];
        end
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        qs_r[k]   <= qs_nxt[k];
        tag_r[k]  <= (k == 0) ? in_tag : tag_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

@@ hdl/sphere_to_shape_distance.sv @@
// Top level of the sphere-to-shape distance pipeline.
//
// Usage: one item on the in_ channel carries a shape kind, two packed centres,
// two packed axes and two sizes; one item on the out_ channel carries the
// distance and an error flag for an unknown kind. Both channels use valid and
// stall: an item moves on a rising edge with valid high and stall low.
// An accepted input item passes 11 geometry stages, 8 square-root stages of
// four root bits and 1 output register. Throughput: one item per cycle unless
// the receiver stalls; the depth is set by the chain of products with the
// axes and by the bitwise square-root pipeline.
// Every stage holds a valid bit, so empty stages fill while the output is
// stalled; in_stall rises only when every stage holds an item and the
// receiver stalls. Items keep order and are neither lost nor repeated.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline is empty
// and ready in the first cycle after reset.
module sphere_to_shape_distance (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_other_kind,
  input  logic [62:0]             in_sphere_center,
  input  logic [62:0]             in_other_center,
  input  logic [62:0]             in_axis_normal,
  input  logic [62:0]             in_axis_in_plane,
  input  logic [stsd_pkg::SZW-1:0] in_size_first,
  input  logic [stsd_pkg::SZW-1:0] in_size_second,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [stsd_pkg::SZW-1:0] out_distance,
  output logic                    out_kind_error
);

  localparam int CB   = stsd_pkg::COMPONENT_BITS;
  localparam int AXF  = stsd_pkg::AXF;
  localparam int SZW  = stsd_pkg::SZW;
  localparam int DW   = CB + 1;              // centre offset
  localparam int ZXW  = 2 * CB;              // axis by axis
  localparam int YW   = ZXW + 1 - AXF;       // y axis
  localparam int DZP  = DW + CB;             // offset by axis
  localparam int DZ2W = DZP + 2 - (AXF - 1); // doubled normal coordinate
  localparam int PZW  = DZ2W + CB;
  localparam int P2W  = PZW - AXF + 1;       // doubled in-plane offset
  localparam int A2W  = SZW + 1;             // clamped coordinate
  localparam int ZAW  = CB + A2W;
  localparam int PXP  = P2W + CB;
  localparam int PYP  = P2W + YW;
  localparam int CXW  = CB + A2W;
  localparam int CYW  = YW + A2W;
  localparam int VW   = CYW + 1 - AXF + 1;   // final doubled vector
  localparam int NS   = 11;                  // geometry stages

  typedef struct packed {
    logic [2:0]           kind;
    logic                 dzero;
    logic [2:0][DW-1:0]   d;
    logic [2:0][CB-1:0]   z;
    logic [2:0][CB-1:0]   x;
    logic [2:0][YW-1:0]   y;
    logic [2:0][VW-1:0]   vc;
    logic [SZW-1:0]       sz1;
    logic [SZW-1:0]       sz2;
  } side_t;

  // Arithmetic shift right by n that rounds half up.
  function automatic logic signed [63:0] rsr(input logic signed [63:0] v,
                                             input int unsigned n);
    rsr = (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Symmetric clamp to +/- lim.
  function automatic logic signed [A2W-1:0] clampv(input logic signed [63:0] v,
                                                   input logic [SZW-1:0] lim);
    logic signed [63:0] l;
    l = $signed({{(64-SZW){1'b0}}, lim});
    if (v > l) begin
      clampv = A2W'(l);
    end else if (v < -l) begin
      clampv = A2W'(-l);
    end else begin
      clampv = A2W'(v);
    end
  endfunction

  logic [NS-1:0] vld_r;
  logic [NS:0]   adv;
  side_t         sd_r   [NS];
  side_t         sd_nxt [NS];

  logic signed [ZXW-1:0]  zx_r [6];
  logic signed [ZXW-1:0]  zx_nxt [6];
  logic signed [DZP-1:0]  dz_r [3];
  logic signed [DZP-1:0]  dz_nxt [3];
  logic signed [DZ2W-1:0] dz2_r, dz2_nxt;
  logic signed [PZW-1:0]  pz_r [3];
  logic signed [PZW-1:0]  pz_nxt [3];
  logic signed [A2W-1:0]  a2_r, a2_nxt;
  logic signed [P2W-1:0]  p2_r [3];
  logic signed [P2W-1:0]  p2_nxt [3];
  logic signed [ZAW-1:0]  za_r [3];
  logic signed [ZAW-1:0]  za_nxt [3];
  logic signed [PXP-1:0]  pxp_r [3];
  logic signed [PXP-1:0]  pxp_nxt [3];
  logic signed [PYP-1:0]  pyp_r [3];
  logic signed [PYP-1:0]  pyp_nxt [3];
  logic signed [A2W-1:0]  px2_r, px2_nxt, py2_r, py2_nxt;
  logic signed [CXW-1:0]  cx_r [3];
  logic signed [CXW-1:0]  cx_nxt [3];
  logic signed [CYW-1:0]  cy_r [3];
  logic signed [CYW-1:0]  cy_nxt [3];
  logic signed [VW-1:0]   v_r [3];
  logic signed [VW-1:0]   v_nxt [3];
  logic [stsd_pkg::QW-1:0] sq_r [3];
  logic [stsd_pkg::QW-1:0] sq_nxt [3];
  logic [stsd_pkg::QW-1:0] q_r, q_nxt;

  logic                    sq_in_stall;
  logic                    sq_out_valid;
  logic                    sq_out_stall;
  logic [stsd_pkg::RW-1:0] sq_root;
  stsd_pkg::sq_tag_t       sq_tag_in, sq_tag_out;

  logic                    out_valid_r;
  logic [SZW-1:0]          out_distance_r, out_distance_nxt;
  logic                    out_kind_error_r, out_kind_error_nxt;
  logic                    adv_o;

  // Stall chain through the geometry stages.
  always_comb begin
    adv[NS] = !sq_in_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  // Geometry datapath, one group of products or sums per stage.
  always_comb begin
    logic signed [63:0] t;
    for (int k = 1; k < NS; k++) begin
      sd_nxt[k] = sd_r[k-1];
    end

    // Unpack and take the centre offset.
    sd_nxt[0].kind  = in_other_kind;
    sd_nxt[0].dzero = (in_sphere_center[3*CB-1:0] == in_other_center[3*CB-1:0]);
    sd_nxt[0].sz1   = in_size_first;
    sd_nxt[0].sz2   = in_size_second;
    sd_nxt[0].y     = '0;
    sd_nxt[0].vc    = '0;
    for (int i = 0; i < 3; i++) begin
      sd_nxt[0].d[i] = DW'($signed(in_sphere_center[i*CB +: CB]))
                     - DW'($signed(in_other_center[i*CB +: CB]));
      sd_nxt[0].z[i] = in_axis_normal[i*CB +: CB];
      sd_nxt[0].x[i] = in_axis_in_plane[i*CB +: CB];
    end

    // Cross-product terms and offset along the normal.
    zx_nxt[0] = $signed(sd_r[0].z[1]) * $signed(sd_r[0].x[2]);
    zx_nxt[1] = $signed(sd_r[0].z[2]) * $signed(sd_r[0].x[1]);
    zx_nxt[2] = $signed(sd_r[0].z[2]) * $signed(sd_r[0].x[0]);
    zx_nxt[3] = $signed(sd_r[0].z[0]) * $signed(sd_r[0].x[2]);
    zx_nxt[4] = $signed(sd_r[0].z[0]) * $signed(sd_r[0].x[1]);
    zx_nxt[5] = $signed(sd_r[0].z[1]) * $signed(sd_r[0].x[0]);
    for (int i = 0; i < 3; i++) begin
      dz_nxt[i] = $signed(sd_r[0].d[i]) * $signed(sd_r[0].z[i]);
    end

    // y axis and doubled normal coordinate.
    for (int i = 0; i < 3; i++) begin
      t = rsr(zx_r[2*i] - zx_r[2*i+1], AXF);
      sd_nxt[2].y[i] = t[YW-1:0];
    end
    t = rsr(dz_r[0] + dz_r[1] + dz_r[2], AXF - 1);
    dz2_nxt = t[DZ2W-1:0];

    // Normal component back along the axis; cylinder clamp.
    for (int i = 0; i < 3; i++) begin
      pz_nxt[i] = dz2_r * $signed(sd_r[2].z[i]);
    end
    a2_nxt = clampv(dz2_r, sd_r[2].sz1);

    // In-plane offset; cylinder axis point.
    for (int i = 0; i < 3; i++) begin
      t = (64'($signed(sd_r[3].d[i])) <<< 1) - rsr(pz_r[i], AXF);
      p2_nxt[i] = t[P2W-1:0];
      za_nxt[i] = $signed(sd_r[3].z[i]) * a2_r;
    end

    // Plate coordinate products; cylinder vector.
    for (int i = 0; i < 3; i++) begin
      pxp_nxt[i] = p2_r[i] * $signed(sd_r[4].x[i]);
      pyp_nxt[i] = p2_r[i] * $signed(sd_r[4].y[i]);
      t = rsr(za_r[i], AXF) - (64'($signed(sd_r[4].d[i])) <<< 1);
      sd_nxt[5].vc[i] = t[VW-1:0];
    end

    // Clamp plate coordinates.
    px2_nxt = clampv(rsr(pxp_r[0] + pxp_r[1] + pxp_r[2], AXF), sd_r[5].sz1);
    py2_nxt = clampv(rsr(pyp_r[0] + pyp_r[1] + pyp_r[2], AXF), sd_r[5].sz2);

    // Clamped point products.
    for (int i = 0; i < 3; i++) begin
      cx_nxt[i] = $signed(sd_r[6].x[i]) * px2_r;
      cy_nxt[i] = $signed(sd_r[6].y[i]) * py2_r;
    end

    // Pick the vector for this kind.
    for (int i = 0; i < 3; i++) begin
      if (sd_r[7].kind == stsd_pkg::KIND_PLATE ||
          sd_r[7].kind == stsd_pkg::KIND_PLATE_HOLE) begin
        t = rsr(cx_r[i] + cy_r[i], AXF) - (64'($signed(sd_r[7].d[i])) <<< 1);
      end else if (sd_r[7].kind == stsd_pkg::KIND_CYLINDER) begin
        t = 64'($signed(sd_r[7].vc[i]));
      end else begin
        t = 64'($signed(sd_r[7].d[i])) <<< 1;
      end
      v_nxt[i] = t[VW-1:0];
    end

    // Squares and squared norm.
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = stsd_pkg::QW'(v_r[i]) * stsd_pkg::QW'(v_r[i]);
    end
    q_nxt = sq_r[0] + sq_r[1] + sq_r[2];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[k-1];
        end
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        sd_r[k] <= sd_nxt[k];
      end
    end
    if (adv[1]) begin
      zx_r <= zx_nxt;
      dz_r <= dz_nxt;
    end
    if (adv[2]) begin
      dz2_r <= dz2_nxt;
    end
    if (adv[3]) begin
      pz_r <= pz_nxt;
      a2_r <= a2_nxt;
    end
    if (adv[4]) begin
      p2_r <= p2_nxt;
      za_r <= za_nxt;
    end
    if (adv[5]) begin
      pxp_r <= pxp_nxt;
      pyp_r <= pyp_nxt;
    end
    if (adv[6]) begin
      px2_r <= px2_nxt;
      py2_r <= py2_nxt;
    end
    if (adv[7]) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
    end
    if (adv[8]) begin
      v_r <= v_nxt;
    end
    if (adv[9]) begin
      sq_r <= sq_nxt;
    end
    if (adv[10]) begin
      q_r <= q_nxt;
    end
  end

  assign sq_tag_in.kind  = sd_r[NS-1].kind;
  assign sq_tag_in.dzero = sd_r[NS-1].dzero;
  assign sq_tag_in.sz1   = sd_r[NS-1].sz1;

  stsd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[NS-1]),
    .in_stall  (sq_in_stall),
    .in_q      (q_r),
    .in_tag    (sq_tag_in),
    .out_valid (sq_out_valid),
    .out_stall (sq_out_stall),
    .out_root  (sq_root),
    .out_tag   (sq_tag_out)
  );

  // Rounding, triangle offset, error and saturation.
  always_comb begin
    logic [stsd_pkg::RW:0]   sum;
    logic [stsd_pkg::RW-1:0] half;
    sum = {1'b0, sq_root} + (stsd_pkg::RW+1)'(1);
    if (sq_tag_out.kind == stsd_pkg::KIND_TRIANGLE) begin
      sum = sum + (stsd_pkg::RW+1)'(sq_tag_out.sz1);
    end
    half = sum[stsd_pkg::RW:1];
    out_kind_error_nxt = (sq_tag_out.kind > 3'(stsd_pkg::KIND_CYLINDER));
    if (out_kind_error_nxt ||
        (sq_tag_out.kind == stsd_pkg::KIND_TRIANGLE && sq_tag_out.dzero)) begin
      out_distance_nxt = '0;
    end else if (half > stsd_pkg::RW'(stsd_pkg::DIST_MAX)) begin
      out_distance_nxt = stsd_pkg::DIST_MAX;
    end else begin
      out_distance_nxt = half[SZW-1:0];
    end
  end

  assign adv_o        = !out_valid_r || !out_stall;
  assign sq_out_stall = !adv_o;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_o) begin
      out_valid_r <= sq_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      out_distance_r   <= out_distance_nxt;
      out_kind_error_r <= out_kind_error_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_distance   = out_distance_r;
  assign out_kind_error = out_kind_error_r;

endmodule

@@ hdl/stsd_checker.sv @@
// Port-level checks of the distance block and their bind.
`include "sphere_to_shape_distance_macros.svh"

module stsd_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [2:0]               in_other_kind,
  input logic [62:0]              in_sphere_center,
  input logic [62:0]              in_other_center,
  input logic [62:0]              in_axis_normal,
  input logic [62:0]              in_axis_in_plane,
  input logic [stsd_pkg::SZW-1:0] in_size_first,
  input logic [stsd_pkg::SZW-1:0] in_size_second,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [stsd_pkg::SZW-1:0] out_distance,
  input logic                     out_kind_error
);

  logic                               in_busy;
  logic                               out_busy;
  logic                               out_err;
  logic [3+4*63+2*stsd_pkg::SZW-1:0]  in_payload;
  logic [stsd_pkg::SZW:0]             out_payload;

  // Waiting items and their payloads.
  assign in_busy     = in_valid && in_stall;
  assign out_busy    = out_valid && out_stall;
  assign out_err     = out_valid && out_kind_error;
  assign in_payload  = {in_other_kind, in_sphere_center, in_other_center, in_axis_normal,
                        in_axis_in_plane, in_size_first, in_size_second};
  assign out_payload = {out_distance, out_kind_error};

  // A stalled input item holds.
  `STSD_ASSERT(a_in_hold, in_busy |=> in_valid && $stable(in_payload), "held item changed")

  // A stalled result holds.
  `STSD_ASSERT(a_out_hold, out_busy |=> out_valid && $stable(out_payload), "held result changed")

  // An unknown kind reports zero distance.
  `STSD_ASSERT(a_err_zero, out_err |-> out_distance == '0, "error item with nonzero distance")

  // Input stalls only behind a stalled result.
  `STSD_ASSERT(a_stall_cause, in_stall |-> out_busy, "input stalled with output free")

  // Reset empties the pipeline.
  `STSD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "not empty after reset")

endmodule

bind sphere_to_shape_distance stsd_checker u_stsd_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the sphere-to-shape distance pipeline.
`timescale 1ns / 100ps

module testbench;

  localparam int UNIT = 1 << 19;   // axis value 1.0
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    logic [23:0] distance;
    logic        kind_error;
  } dist_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_other_kind = '0;
  logic [62:0] in_sphere_center = '0;
  logic [62:0] in_other_center = '0;
  logic [62:0] in_axis_normal = '0;
  logic [62:0] in_axis_in_plane = '0;
  logic [stsd_pkg::SZW-1:0] in_size_first = '0;
  logic [stsd_pkg::SZW-1:0] in_size_second = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [stsd_pkg::SZW-1:0] out_distance;
  logic out_kind_error;

  dist_result_t pending_dist[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit send_gaps = 1'b0;
  bit recv_gaps = 1'b0;
  bit hold_go = 1'b0;
  int hold_left = 0;

  sphere_to_shape_distance i_dut (.*);

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed component i of a packed vector
  function automatic longint comp(logic [62:0] w, int i);
    logic [20:0] c;
    c = w[i*21 +: 21];
    return longint'(signed'(c));
  endfunction

  function automatic logic [62:0] pack3(longint a, longint b, longint c);
    logic [20:0] x0, x1, x2;
    x0 = a[20:0];
    x1 = b[20:0];
    x2 = c[20:0];
    return {x2, x1, x0};
  endfunction

  // Shift right, rounding half toward plus infinity
  function automatic longint rnd(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Length of a doubled-unit vector, rounded half up
  function automatic longint unsigned half_len(longint v[3], longint unsigned extra);
    longint unsigned q;
    q = 0;
    for (int i = 0; i < 3; i++) q += longint'(v[i] * v[i]);
    return (int_sqrt(q) + extra + 1) >> 1;
  endfunction

  // Expected distance of one item
  function automatic dist_result_t predict_distance(logic [2:0] kind,
      logic [62:0] sc, logic [62:0] oc, logic [62:0] zn, logic [62:0] xp,
      logic [stsd_pkg::SZW-1:0] sz1, logic [stsd_pkg::SZW-1:0] sz2);
    dist_result_t res;
    longint d[3], z[3], x[3], y[3], v2[3], p2[3];
    longint dz2, px2, py2, a2, dotp;
    longint unsigned dlen;
    for (int i = 0; i < 3; i++) begin
      d[i] = comp(sc, i) - comp(oc, i);
      z[i] = comp(zn, i);
      x[i] = comp(xp, i);
      v2[i] = 2 * d[i];
    end
    dlen = 0;
    res.kind_error = 1'b0;
    case (kind)
      stsd_pkg::KIND_SPHERE: dlen = half_len(v2, 64'd0);
      stsd_pkg::KIND_TRIANGLE: begin
        if (d[0] != 0 || d[1] != 0 || d[2] != 0) dlen = half_len(v2, 64'(sz1));
      end
      stsd_pkg::KIND_PLATE, stsd_pkg::KIND_PLATE_HOLE: begin
        y[0] = rnd(z[1] * x[2] - z[2] * x[1], stsd_pkg::AXF);
        y[1] = rnd(z[2] * x[0] - z[0] * x[2], stsd_pkg::AXF);
        y[2] = rnd(z[0] * x[1] - z[1] * x[0], stsd_pkg::AXF);
        dz2 = rnd(d[0] * z[0] + d[1] * z[1] + d[2] * z[2], stsd_pkg::AXF - 1);
        for (int i = 0; i < 3; i++) p2[i] = 2 * d[i] - rnd(dz2 * z[i], stsd_pkg::AXF);
        dotp = p2[0] * x[0] + p2[1] * x[1] + p2[2] * x[2];
        px2 = clamp(rnd(dotp, stsd_pkg::AXF), longint'(sz1));
        dotp = p2[0] * y[0] + p2[1] * y[1] + p2[2] * y[2];
        py2 = clamp(rnd(dotp, stsd_pkg::AXF), longint'(sz2));
        for (int i = 0; i < 3; i++)
          v2[i] = rnd(x[i] * px2 + y[i] * py2, stsd_pkg::AXF) - 2 * d[i];
        dlen = half_len(v2, 64'd0);
      end
      stsd_pkg::KIND_CYLINDER: begin
        a2 = clamp(rnd(d[0] * z[0] + d[1] * z[1] + d[2] * z[2], stsd_pkg::AXF - 1),
                   longint'(sz1));
        for (int i = 0; i < 3; i++) v2[i] = rnd(z[i] * a2, stsd_pkg::AXF) - 2 * d[i];
        dlen = half_len(v2, 64'd0);
      end
      default: res.kind_error = 1'b1;
    endcase
    res.distance = (dlen > 64'hFFFFFF) ? 24'hFFFFFF : dlen[23:0];
    return res;
  endfunction

  task automatic report(string what, logic [23:0] got, logic [23:0] want);
    $display("error: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Input capture, result check and watchdog
  always @(posedge clk) begin
    dist_result_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        pending_dist.push_back(predict_distance(in_other_kind, in_sphere_center,
          in_other_center, in_axis_normal, in_axis_in_plane, in_size_first,
          in_size_second));
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (pending_dist.size() == 0) begin
          report("unexpected item, distance", out_distance, 24'd0);
        end else begin
          want = pending_dist.pop_front();
          if (out_distance !== want.distance)
            report("distance", out_distance, want.distance);
          if (out_kind_error !== want.kind_error)
            report("kind_error", 24'(out_kind_error), 24'(want.kind_error));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("sphere_to_shape_distance: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stalls and a long hold-off on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = 80;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = recv_gaps && ($urandom_range(99) < 23);
    end
  end

  // Offer one item; returns at the falling edge after it is accepted
  task automatic send_item(logic [2:0] kind, logic [62:0] sc, logic [62:0] oc,
      logic [62:0] zn, logic [62:0] xp, logic [stsd_pkg::SZW-1:0] sz1,
      logic [stsd_pkg::SZW-1:0] sz2);
    while (send_gaps && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_other_kind = kind;
    in_sphere_center = sc;
    in_other_center = oc;
    in_axis_normal = zn;
    in_axis_in_plane = xp;
    in_size_first = sz1;
    in_size_second = sz2;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [62:0] rand_wide();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic longint rand_coord(bit wide);
    if (wide) return longint'($urandom_range(2097151)) - 1048576;
    return longint'($urandom_range(8191)) - 4096;
  endfunction

  // Random item, mostly well-formed orthonormal axes and moderate sizes
  task automatic send_random();
    logic [2:0] kind;
    logic [62:0] sc, oc, zn, xp;
    longint zv[3], xv[3];
    int zi, xi;
    bit wide;
    kind = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    wide = ($urandom_range(3) == 0);
    sc = pack3(rand_coord(wide), rand_coord(wide), rand_coord(wide));
    if ($urandom_range(19) == 0) oc = sc;
    else oc = pack3(rand_coord(wide), rand_coord(wide), rand_coord(wide));
    if ($urandom_range(4) == 0) begin
      zn = rand_wide();
      xp = rand_wide();
    end else begin
      zi = $urandom_range(2);
      xi = (zi + 1 + $urandom_range(1)) % 3;
      for (int i = 0; i < 3; i++) begin
        zv[i] = longint'($urandom_range(64)) - 32;
        xv[i] = longint'($urandom_range(64)) - 32;
      end
      zv[zi] = $urandom_range(1) ? UNIT - 1 : 1 - UNIT;
      xv[xi] = $urandom_range(1) ? UNIT - 1 : 1 - UNIT;
      zn = pack3(zv[0], zv[1], zv[2]);
      xp = pack3(xv[0], xv[1], xv[2]);
    end
    if ($urandom_range(4) == 0)
      send_item(kind, sc, oc, zn, xp, 24'($urandom), 24'($urandom));
    else
      send_item(kind, sc, oc, zn, xp, 24'($urandom_range(6000)),
                24'($urandom_range(6000)));
  endtask

  // Extremes, every kind and the boundary cases
  task automatic test_directed();
    logic [62:0] zu, xu, pmax, pmin;
    zu = pack3(0, 0, UNIT);
    xu = pack3(UNIT, 0, 0);
    pmax = pack3(1048575, 1048575, 1048575);
    pmin = pack3(-1048576, -1048576, -1048576);
    for (int k = 0; k < 8; k++) begin
      send_item(3'(k), pmax, pmin, zu, xu, 24'hFFFFFF, 24'hFFFFFF);
      send_item(3'(k), pack3(10, -20, 30), pack3(-5, 7, 0), zu, xu, 24'd40, 24'd60);
    end
    // coincident centres: zero-offset triangle
    send_item(stsd_pkg::KIND_TRIANGLE, pack3(123, 45, -6), pack3(123, 45, -6), zu, xu,
              24'd500, 24'd0);
    // in-plane offset exactly on the half width and half length
    send_item(stsd_pkg::KIND_PLATE, pack3(50, 0, 7), '0, zu, xu, 24'd100, 24'd0);
    send_item(stsd_pkg::KIND_PLATE_HOLE, pack3(0, -30, 9), '0, zu, xu, 24'd0, 24'd60);
    // axial offset exactly on the half height
    send_item(stsd_pkg::KIND_CYLINDER, pack3(0, 0, 40), '0, zu, xu, 24'd80, 24'd0);
    // all-ones and all-zero fields, axes at their extremes
    send_item(stsd_pkg::KIND_PLATE, '1, '0, pmax, pmin, 24'hFFFFFF, 24'd0);
    send_item(stsd_pkg::KIND_CYLINDER, '0, '1, pmin, pmax, 24'd0, 24'hFFFFFF);
    send_item(stsd_pkg::KIND_PLATE, pmin, pmax, pmin, pmin, 24'hFFFFFF, 24'hFFFFFF);
    in_valid = 1'b0;
  endtask

  // Random items with idling on both sides, then a stretch with none
  task automatic test_random();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    repeat (350) send_random();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    repeat (100) send_random();
    in_valid = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    send_gaps = 1'b0;
    hold_go = 1'b1;
    repeat (60) send_random();
    in_valid = 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    wait (pending_dist.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sphere_to_shape_distance: match");
    end else begin
      $display("sphere_to_shape_distance: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/stsd_pkg.sv
hdl/stsd_isqrt.sv
hdl/sphere_to_shape_distance.sv
hdl/stsd_checker.sv
tb/sv/testbench.sv
